// ----- sv/signature_match_table_macros.svh -----
// Assertion macros shared by the table's checks.
`ifndef SIGNATURE_MATCH_TABLE_MACROS_SVH
`define SIGNATURE_MATCH_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SMT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/smt_pkg.sv -----
package smt_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int SAMPLES_DEF   = 4;
   localparam int SAMPLE_FIELDS = 4;

   localparam int OP_W     = 2;
   localparam int ID_W     = 16;
   localparam int SAMPLE_W = 16;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 4;

   localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
   localparam logic [OP_W-1:0] OP_FIND_SIG = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND_ID  = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

endpackage

// ----- sv/signature_match_table.sv -----
// Channel   | Ports                                               | Beat taken when
// ----------+-----------------------------------------------------+------------------------
// request   | start, busy, req_op, req_threat_id, req_sample_0..3 | start && !busy
// response  | rsp_valid, rsp_status, rsp_entry_index              | rsp_valid (one cycle)
//
// Add, a rejected add, a search of an empty table and an undefined op answer at once:
// the response beat shows in the cycle after the request beat and busy stays low.
// A search scans one entry per cycle, each compared in the cycle after its read: busy is
// high until a hit or the last filled entry is compared, then the response beat shows.
// Reset (synchronous, active high) empties the table; entries are compared below fill only.
// The response beat cannot be stalled; a new request may be taken while it shows.

`include "signature_match_table_macros.svh"

module signature_match_table #(
   parameter int DEPTH   = smt_pkg::DEPTH_DEF,
   parameter int SAMPLES = smt_pkg::SAMPLES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic        [smt_pkg::OP_W-1:0]     req_op,
   input  logic        [smt_pkg::ID_W-1:0]     req_threat_id,
   input  logic signed [smt_pkg::SAMPLE_W-1:0] req_sample_0,
   input  logic signed [smt_pkg::SAMPLE_W-1:0] req_sample_1,
   input  logic signed [smt_pkg::SAMPLE_W-1:0] req_sample_2,
   input  logic signed [smt_pkg::SAMPLE_W-1:0] req_sample_3,
   output logic                               rsp_valid,
   output logic        [smt_pkg::STATUS_W-1:0] rsp_status,
   output logic        [smt_pkg::INDEX_W-1:0]  rsp_entry_index
);

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int INDEX_W = smt_pkg::INDEX_W;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            fill_ff, fill_in;
   logic [smt_pkg::OP_W-1:0]    op_ff, op_in;
   logic [IDX_W-1:0]            addr_ff, addr_in;
   logic                        cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]            cmp_idx_ff, cmp_idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   smt_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]          rsp_entry_index_ff, rsp_entry_index_in;

   logic                        wr_en;
   logic                        key_load;
   logic                        full;
   logic                        cmp_last;
   logic                        hit;
   logic [SAMPLES-1:0]          sig_match;
   logic                        id_match;
   logic [smt_pkg::SAMPLE_W-1:0] field_sample [smt_pkg::SAMPLE_FIELDS];
   logic [smt_pkg::SAMPLE_W-1:0] lane_data    [SAMPLES];

   // Gather the sample fields; samples past the last field are stored as zero.
   assign field_sample[0] = req_sample_0;
   assign field_sample[1] = req_sample_1;
   assign field_sample[2] = req_sample_2;
   assign field_sample[3] = req_sample_3;

   always_comb begin
      for (int j = 0; j < SAMPLES; j++) begin
         if (j < smt_pkg::SAMPLE_FIELDS) begin
            lane_data[j] = field_sample[j % smt_pkg::SAMPLE_FIELDS];
         end else begin
            lane_data[j] = '0;
         end
      end
   end

   // One lane per sample, each scanning the same entry in the same cycle.
   for (genvar g = 0; g < SAMPLES; g++) begin : g_sig_lane
      smt_lane #(.DEPTH(DEPTH)) u_lane (
         .clock    (clock),
         .wr_en    (wr_en),
         .wr_addr  (fill_ff[IDX_W-1:0]),
         .data     (lane_data[g]),
         .key_load (key_load),
         .rd_addr  (addr_ff),
         .match    (sig_match[g])
      );
   end

   // The identifier column is one more lane of the same kind.
   smt_lane #(.DEPTH(DEPTH)) u_id_lane (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (fill_ff[IDX_W-1:0]),
      .data     (req_threat_id),
      .key_load (key_load),
      .rd_addr  (addr_ff),
      .match    (id_match)
   );

   smt_merge #(.SAMPLES(SAMPLES)) u_merge (
      .op        (op_ff),
      .sig_match (sig_match),
      .id_match  (id_match),
      .hit       (hit)
   );

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign cmp_last = (CNT_W'(cmp_idx_ff) == (fill_ff - CNT_W'(1)));

   always_comb begin
      state_in           = state_ff;
      fill_in            = fill_ff;
      op_in              = op_ff;
      addr_in            = addr_ff;
      cmp_valid_in       = 1'b0;
      cmp_idx_in         = addr_ff;
      rsp_valid_in       = 1'b0;
      rsp_status_in      = rsp_status_ff;
      rsp_entry_index_in = rsp_entry_index_ff;
      wr_en              = 1'b0;
      key_load           = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               // Latch the op and search keys; default answer is not found.
               key_load           = 1'b1;
               op_in              = req_op;
               addr_in            = '0;
               rsp_valid_in       = 1'b1;
               rsp_status_in      = smt_pkg::ST_NOT_FOUND;
               rsp_entry_index_in = '0;
               unique case (req_op)
                  smt_pkg::OP_ADD: begin
                     if (full) begin
                        rsp_status_in = smt_pkg::ST_FULL;
                     end else begin
                        wr_en              = 1'b1;
                        fill_in            = fill_ff + CNT_W'(1);
                        rsp_status_in      = smt_pkg::ST_OK;
                        rsp_entry_index_in = INDEX_W'(fill_ff);
                     end
                  end
                  smt_pkg::OP_FIND_SIG: begin
                     if (fill_ff == '0) begin
                        rsp_status_in = smt_pkg::ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                     end
                  end
                  smt_pkg::OP_FIND_ID: begin
                     // No empty check here: an empty table just misses.
                     if (fill_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Issue the next read while the previous entry is compared.
            addr_in    = addr_ff + IDX_W'(1);
            cmp_idx_in = addr_ff;
            if (cmp_valid_ff && hit) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = smt_pkg::ST_OK;
               rsp_entry_index_in = INDEX_W'(cmp_idx_ff);
               state_in           = S_IDLE;
            end else if (cmp_valid_ff && cmp_last) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = smt_pkg::ST_NOT_FOUND;
               rsp_entry_index_in = '0;
               state_in           = S_IDLE;
            end else begin
               cmp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff              <= op_in;
      addr_ff            <= addr_in;
      cmp_idx_ff         <= cmp_idx_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_entry_index_ff <= rsp_entry_index_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_entry_index_ff;

   // Every accepted beat either answers next cycle or starts a scan.
   `SMT_ASSERT_NEXT(a_accept_answers, clock, reset, start && !busy,
                    rsp_valid || busy, "accepted beat neither answered nor scanning")
   // An add into a table with room grows the fill count by one.
   `SMT_ASSERT_NEXT(a_add_grows, clock, reset,
                    start && !busy && req_op == smt_pkg::OP_ADD && !full,
                    fill_ff == $past(fill_ff) + CNT_W'(1), "add did not advance fill count")
   // Anything but a hit or a stored add reports index zero.
   `SMT_ASSERT_SAME(a_miss_index_zero, clock, reset,
                    rsp_valid && rsp_status != smt_pkg::ST_OK,
                    rsp_entry_index == '0, "nonzero index on a miss")

endmodule

// ----- sv/smt_lane.sv -----
// One compare lane: a column of the table with a latched search key.
module smt_lane #(
   parameter int DEPTH = smt_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [smt_pkg::SAMPLE_W-1:0]  data,
   input  logic                          key_load,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic                          match
);

   logic [smt_pkg::SAMPLE_W-1:0] store_mem [DEPTH];
   logic [smt_pkg::SAMPLE_W-1:0] rd_ff;
   logic [smt_pkg::SAMPLE_W-1:0] key_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= data;
      end
      rd_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (key_load) begin
         key_ff <= data;
      end
   end

   assign match = (rd_ff == key_ff);

endmodule

// ----- sv/smt_merge.sv -----
// Merge lane results: all sample lanes for a signature search, id lane for an id search.
module smt_merge #(
   parameter int SAMPLES = smt_pkg::SAMPLES_DEF
) (
   input  logic [smt_pkg::OP_W-1:0] op,
   input  logic [SAMPLES-1:0]       sig_match,
   input  logic                     id_match,
   output logic                     hit
);

   always_comb begin
      unique case (op)
         smt_pkg::OP_FIND_SIG: hit = &sig_match;
         smt_pkg::OP_FIND_ID:  hit = id_match;
         default:              hit = 1'b0;
      endcase
   end

endmodule
